[design/swhc_pkg.sv]
package swhc_pkg;

  // Ring size. The bucket index is the low bits of the timestamp, so the ring
  // depth is kept a power of two.
  localparam int unsigned WINDOW = 256;
  localparam int unsigned IDX_W  = $clog2(WINDOW);
  localparam int unsigned TS_W   = 32;
  localparam int unsigned CNT_W  = 16;
  localparam int unsigned SUM_W  = 24;

  typedef enum logic {
    ACT_HIT   = 1'b0,
    ACT_QUERY = 1'b1
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HIT_RD,
    ST_HIT_WR,
    ST_Q_SCAN,
    ST_Q_DONE
  } state_t;

  typedef struct packed {
    logic [TS_W-1:0]  stamp;
    logic [CNT_W-1:0] count;
  } bucket_t;

  // Controller -> datapath
  typedef struct packed {
    logic capture;   // latch timestamp, clear scan index and accumulator
    logic rd_hit;    // read bucket at timestamp index
    logic rd_scan;   // read bucket at scan index, advance index
    logic wr_hit;    // write updated bucket back
    logic out_load;  // move accumulator into output register
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic scan_last;  // scan index is on the last bucket
    logic pipe_busy;  // query reads still in flight
    logic out_free;   // output register can take a new item
  } sts_t;

endpackage

[design/sliding_window_hit_counter_core.sv]
// Sliding-window hit counter, bucket ring of WINDOW (256) entries.
//
// Input channel in_*: one item per handshake. in_tuser is the action
// (0 = record a hit, 1 = query), in_tdata the 32-bit timestamp, which should
// not decrease from item to item. A hit gives no output; a query gives one
// output item on out_*, out_tdata = 24-bit sum of the counts of all buckets
// stamped within the last WINDOW time units.
//
// Sequence: a hit passes through accept, read and write back of its bucket. A
// query is accepted, then the scan reads every bucket once through the single
// port of the bucket store, then two pipeline stages settle the sum before it
// is loaded into the output register. in_tready is high only between items.
//
// Reset (rst_n low, synchronous): controller to idle, output emptied, and a
// per-bucket valid flag cleared so every bucket reads as stamp 0, count 0.
// No clearing pass is needed; the block takes items right after reset.
// Backpressure: the result sits in an output register. While out_tready is
// low the block still accepts and records hits; a further query completes its
// scan and then waits until the output register frees up.
module sliding_window_hit_counter_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] timestamp
  input  logic        in_tuser,   // [0] action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [23:0] hit_total
);
  import swhc_pkg::*;

  cmd_t    cmd;
  sts_t    sts;
  action_t in_action;

  assign in_action = action_t'(in_tuser);

  // Sequencer: hit read-modify-write, query scan and result handoff.
  swhc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_action (in_action),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Bucket store, window compare, saturating accumulator, output register.
  swhc_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_ts      (in_tdata),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

[design/swhc_ctrl.sv]
module swhc_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  swhc_pkg::action_t in_action,
  output logic             in_tready,
  input  swhc_pkg::sts_t   sts,
  output swhc_pkg::cmd_t   cmd
);
  import swhc_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = (in_action == ACT_QUERY) ? ST_Q_SCAN : ST_HIT_RD;
        end
      end
      ST_HIT_RD: begin
        cmd.rd_hit = 1'b1;
        state_nxt  = ST_HIT_WR;
      end
      ST_HIT_WR: begin
        cmd.wr_hit = 1'b1;
        state_nxt  = ST_IDLE;
      end
      ST_Q_SCAN: begin
        cmd.rd_scan = 1'b1;
        if (sts.scan_last) begin
          state_nxt = ST_Q_DONE;
        end
      end
      ST_Q_DONE: begin
        if (!sts.pipe_busy && sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

[design/swhc_dpath.sv]
module swhc_dpath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  swhc_pkg::cmd_t              cmd,
  input  logic [swhc_pkg::TS_W-1:0]   in_ts,
  output swhc_pkg::sts_t              sts,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [swhc_pkg::SUM_W-1:0]  out_tdata
);
  import swhc_pkg::*;

  bucket_t          mem [WINDOW];
  logic [WINDOW-1:0] valid_r;

  logic [TS_W-1:0]  ts_r;
  logic [IDX_W-1:0] scan_idx_r;
  logic [IDX_W-1:0] hit_idx;
  logic [IDX_W-1:0] rd_addr;
  logic             rd_en;

  bucket_t          rd_data_r;
  logic             rd_vld_r;
  logic             rd_pend_r;
  logic             add_pend_r;
  logic [CNT_W-1:0] term_r;
  logic [SUM_W-1:0] acc_r;
  logic [SUM_W-1:0] acc_nxt;
  logic             out_valid_r;
  logic [SUM_W-1:0] out_data_r;

  bucket_t          cur;
  bucket_t          upd;
  logic [TS_W:0]    diff;
  logic             in_win;
  logic [SUM_W:0]   sum_ext;

  assign hit_idx = ts_r[IDX_W-1:0];
  assign rd_addr = cmd.rd_scan ? scan_idx_r : hit_idx;
  assign rd_en   = cmd.rd_hit | cmd.rd_scan;

  // Bucket store, one port per cycle; read data registered.
  always_ff @(posedge clk) begin
    if (cmd.wr_hit) begin
      mem[hit_idx] <= upd;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Never-written buckets read as stamp 0, count 0.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.wr_hit) begin
      valid_r[hit_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_vld_r <= valid_r[rd_addr];
    end
  end

  assign cur = rd_vld_r ? rd_data_r : '0;

  // Hit update: take over on stamp change, else saturating increment.
  always_comb begin
    upd = cur;
    if (cur.stamp != ts_r) begin
      upd.stamp = ts_r;
      upd.count = CNT_W'(1);
    end else if (cur.count != '1) begin
      upd.count = cur.count + CNT_W'(1);
    end
  end

  // Window test: stamp <= ts and ts - stamp < WINDOW.
  assign diff   = {1'b0, ts_r} - {1'b0, cur.stamp};
  assign in_win = !diff[TS_W] && (diff < (TS_W+1)'(WINDOW));

  assign sum_ext = {1'b0, acc_r} + (SUM_W+1)'(term_r);
  assign acc_nxt = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ts_r <= in_ts;
    end
    if (rd_pend_r) begin
      term_r <= in_win ? cur.count : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r <= '0;
      rd_pend_r  <= 1'b0;
      add_pend_r <= 1'b0;
      acc_r      <= '0;
    end else begin
      rd_pend_r  <= cmd.rd_scan;
      add_pend_r <= rd_pend_r;
      if (cmd.capture) begin
        scan_idx_r <= '0;
        acc_r      <= '0;
      end else begin
        if (cmd.rd_scan) begin
          scan_idx_r <= scan_idx_r + IDX_W'(1);
        end
        if (add_pend_r) begin
          acc_r <= acc_nxt;
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= acc_r;
    end
  end

  assign out_tvalid    = out_valid_r;
  assign out_tdata     = out_data_r;
  assign sts.scan_last = (scan_idx_r == IDX_W'(WINDOW - 1));
  assign sts.pipe_busy = rd_pend_r | add_pend_r;
  assign sts.out_free  = !out_valid_r || out_tready;

endmodule

[design/swhc_checker.sv]
module swhc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [31:0] in_tdata,
  input logic        in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output item changed while stalled");

  // One item at a time: busy right after any accept.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("accepted a second item back to back");

  // A hit never produces a result.
  a_hit_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tuser |=> !$rose(out_tvalid))
    else $error("result appeared after a hit");

  // A query keeps the block busy during its scan.
  a_query_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser |-> ##2 !in_tready)
    else $error("query finished too early");

endmodule

bind sliding_window_hit_counter_core swhc_checker u_swhc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
